/* src/iss_pkg.sv */
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types, constants and helpers of the IMU sample scale and filter block.
// ----------------------------------------------------------------------------
package iss_pkg;

    // Axis count
    localparam int ISS_MAX_AXES = 3;
    localparam int ISS_AXES     = 3;

    // Field widths
    localparam int ISS_CMD_W   = 2;
    localparam int ISS_RAW_W   = 16;
    localparam int ISS_VAL_W   = 32;
    localparam int ISS_ALPHA_W = 17;
    localparam int ISS_CFG_W   = 32;
    localparam int ISS_IDX_W   = 3;

    // Stream widths: input padded to whole bytes, output is 12 values
    localparam int ISS_IN_BITS  = ISS_CMD_W + 6 * ISS_RAW_W;
    localparam int ISS_IN_W     = ((ISS_IN_BITS + 7) / 8) * 8;
    localparam int ISS_OUT_W    = 12 * ISS_VAL_W;

    // Weight of one in Q1.16
    localparam logic [ISS_ALPHA_W-1:0] ISS_ONE_Q16 = 17'd65536;

    // Saturation limits
    localparam logic signed [ISS_VAL_W-1:0] ISS_VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ISS_VAL_W-1:0] ISS_VAL_MIN = 32'sh8000_0000;

    // Register reset values
    localparam logic [ISS_CFG_W-1:0]   ISS_ACCEL_GAIN_RST  = 32'd1048576;
    localparam logic [ISS_CFG_W-1:0]   ISS_GYRO_GAIN_RST   = 32'd4570812;
    localparam logic [ISS_CFG_W-1:0]   ISS_GYRO_OFF_X_RST  = 32'd896;
    localparam logic [ISS_CFG_W-1:0]   ISS_GYRO_OFF_Y_RST  = 32'd511;
    localparam logic [ISS_CFG_W-1:0]   ISS_GYRO_OFF_Z_RST  = 32'd734;
    localparam logic [ISS_ALPHA_W-1:0] ISS_ALPHA_RST       = 17'd58982;

    // Configuration register indexes
    typedef enum logic [ISS_IDX_W-1:0] {
        REG_ACCEL_GAIN    = 3'd0,
        REG_GYRO_GAIN     = 3'd1,
        REG_GYRO_OFFSET_X = 3'd2,
        REG_GYRO_OFFSET_Y = 3'd3,
        REG_GYRO_OFFSET_Z = 3'd4,
        REG_ACCEL_ALPHA   = 3'd5,
        REG_GYRO_ALPHA    = 3'd6
    } iss_reg_idx_t;

    // Command codes
    typedef enum logic [ISS_CMD_W-1:0] {
        CMD_BOTH  = 2'd0,
        CMD_GYRO  = 2'd1,
        CMD_ACCEL = 2'd2,
        CMD_NONE  = 2'd3
    } iss_cmd_t;

    // Stage strobes from the sequencer to every lane
    typedef struct packed {
        logic load;      // capture raw readings
        logic mul_en;    // raw times gain
        logic scl_en;    // shift, saturate, offset
        logic prd_en;    // smoother products
        logic smo_en;    // smoother sum
        logic out_load;  // capture stores into the output register
    } iss_ctrl_t;

    // Saturate a 33-bit signed value to 32 bits
    function automatic logic signed [ISS_VAL_W-1:0] iss_sat33(
        input logic signed [ISS_VAL_W:0] v
    );
        logic signed [ISS_VAL_W-1:0] r;
        if (v[ISS_VAL_W] != v[ISS_VAL_W-1])
        begin
            r = v[ISS_VAL_W] ? ISS_VAL_MIN : ISS_VAL_MAX;
        end
        else
        begin
            r = v[ISS_VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/iss_lane.sv */
// ----------------------------------------------------------------------------
// iss_lane
// One axis: scale by gain, subtract offset, saturate, exponential smoothing.
// Holds the scaled and smoothed values of its axis.
// ----------------------------------------------------------------------------
module iss_lane
    import iss_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  iss_ctrl_t                     ctrl,
    input  logic                          active,
    input  logic signed [ISS_RAW_W-1:0]   raw,
    input  logic [ISS_VAL_W-1:0]          gain,
    input  logic signed [ISS_VAL_W-1:0]   offset,
    input  logic [ISS_ALPHA_W-1:0]        alpha,
    output logic signed [ISS_VAL_W-1:0]   scaled,
    output logic signed [ISS_VAL_W-1:0]   smooth
);

    localparam int PROD_W = ISS_RAW_W + ISS_VAL_W + 1;
    localparam int WPRD_W = ISS_VAL_W + ISS_ALPHA_W + 1;
    localparam int SUM_W  = WPRD_W + 1;

    logic signed [ISS_RAW_W-1:0]   raw_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ISS_VAL_W-1:0]   scaled_reg;
    logic signed [ISS_VAL_W-1:0]   scaled_next;
    logic signed [WPRD_W-1:0]      yprod_reg;
    logic signed [WPRD_W-1:0]      xprod_reg;
    logic signed [ISS_VAL_W-1:0]   smooth_reg;
    logic signed [ISS_VAL_W-1:0]   smooth_next;

    logic signed [ISS_VAL_W:0]     gain_s;
    logic [ISS_ALPHA_W-1:0]        alpha_eff;
    logic [ISS_ALPHA_W-1:0]        beta_eff;
    logic signed [ISS_ALPHA_W:0]   alpha_s;
    logic signed [ISS_ALPHA_W:0]   beta_s;
    logic signed [ISS_VAL_W-1:0]   shifted_sat;
    logic signed [ISS_VAL_W:0]     diff;
    logic signed [SUM_W-1:0]       sum;

    // Clamp the weight to one and form its complement
    assign alpha_eff = (alpha > ISS_ONE_Q16) ? ISS_ONE_Q16 : alpha;
    assign beta_eff  = ISS_ONE_Q16 - alpha_eff;
    assign alpha_s   = $signed({1'b0, alpha_eff});
    assign beta_s    = $signed({1'b0, beta_eff});
    assign gain_s    = $signed({1'b0, gain});

    // Floor shift by 16, saturate, subtract offset, saturate again
    assign shifted_sat = iss_sat33(prod_reg[PROD_W-1:16]);
    assign diff        = {shifted_sat[ISS_VAL_W-1], shifted_sat}
                       - {offset[ISS_VAL_W-1], offset};
    assign scaled_next = iss_sat33(diff);

    // Convex sum of the weighted products, floor shift by 16
    assign sum         = {yprod_reg[WPRD_W-1], yprod_reg}
                       + {xprod_reg[WPRD_W-1], xprod_reg};
    assign smooth_next = sum[ISS_VAL_W+15:16];

    // Capture raw reading and run the datapath stages
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            raw_reg <= raw;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(raw_reg) * PROD_W'(gain_s);
        end
        if (ctrl.prd_en)
        begin
            yprod_reg <= WPRD_W'(smooth_reg) * WPRD_W'(alpha_s);
            xprod_reg <= WPRD_W'(scaled_reg) * WPRD_W'(beta_s);
        end
    end

    // Update the per-axis stores when this group is converted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaled_reg <= '0;
            smooth_reg <= '0;
        end
        else
        begin
            if (ctrl.scl_en && active)
            begin
                scaled_reg <= scaled_next;
            end
            if (ctrl.smo_en && active)
            begin
                smooth_reg <= smooth_next;
            end
        end
    end

    assign scaled = scaled_reg;
    assign smooth = smooth_reg;

`ifndef SYNTHESIS
    a_scaled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.scl_en && active) |=> $stable(scaled_reg))
        else $error("scaled value changed outside its stage");

    a_smooth_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.smo_en && active) |=> $stable(smooth_reg))
        else $error("smoothed value changed outside its stage");

    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.smo_en && active && alpha == '0) |=> smooth_reg == $past(scaled_reg))
        else $error("zero weight must pass the scaled value through");
`endif

endmodule

/* src/iss_ctrl.sv */
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer: steps one transaction through the lane stages and loads the
// output register when it is free.
// ----------------------------------------------------------------------------
module iss_ctrl
    import iss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_valid,
    input  logic      out_ready,
    output iss_ctrl_t ctrl
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SCL  = 6'b000100,
        ST_PRD  = 6'b001000,
        ST_SMO  = 6'b010000,
        ST_DONE = 6'b100000
    } iss_state_t;

    iss_state_t state_reg;
    iss_state_t state_next;
    logic       out_free;

    assign out_free = !out_valid || out_ready;

    // Advance through the stages
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SCL;
            ST_SCL:  state_next = ST_PRD;
            ST_PRD:  state_next = ST_SMO;
            ST_SMO:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Stage strobes
    assign in_ready      = (state_reg == ST_IDLE);
    assign ctrl.load     = (state_reg == ST_IDLE) && in_valid;
    assign ctrl.mul_en   = (state_reg == ST_MUL);
    assign ctrl.scl_en   = (state_reg == ST_SCL);
    assign ctrl.prd_en   = (state_reg == ST_PRD);
    assign ctrl.smo_en   = (state_reg == ST_SMO);
    assign ctrl.out_load = (state_reg == ST_DONE) && out_free;

endmodule

/* src/imu_sample_scale_filter.sv */
// ----------------------------------------------------------------------------
// imu_sample_scale_filter
// Scales six-axis IMU samples, removes gyro offsets and smooths each axis
// with a first-order exponential filter; one output transaction per sample.
// ----------------------------------------------------------------------------
//
//  channel   direction  width  contents
//  s_axis    in         104    cmd, accel x/y/z, gyro x/y/z raw readings
//  m_axis    out        384    scaled accel, scaled gyro, smoothed accel/gyro
//  cfg       in         32     register write, index 0..6, no read-back
//
//  The next sample is accepted the cycle after the result is loaded, so the
//  block holds one sample at a time and takes no new sample while one is in
//  flight. The sequencer walks the lanes through
//  multiply, saturate/offset, weighted products and sum, one register each.
//  A result that is not taken stalls the sequencer in its last stage.
//  Reset clears all stores and loads register defaults at once.
// ----------------------------------------------------------------------------
module imu_sample_scale_filter
    import iss_pkg::*;
#(
    parameter int Axes = ISS_AXES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cmd[1:0], accel_x_in, accel_y_in, accel_z_in, gyro_x_in, gyro_y_in,
    // gyro_z_in (16 bits each), zero pad
    input  logic [ISS_IN_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x/y/z_scaled, gyro_x/y/z_scaled, accel_x/y/z_smooth,
    // gyro_x/y/z_smooth (32 bits each)
    output logic [ISS_OUT_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [ISS_IDX_W-1:0]  cfg_index,
    input  logic [ISS_CFG_W-1:0]  cfg_data
);

    localparam int GYRO_BASE = ISS_CMD_W + ISS_MAX_AXES * ISS_RAW_W;

    iss_ctrl_t ctrl;

    logic [ISS_VAL_W-1:0]          accel_gain_reg;
    logic [ISS_VAL_W-1:0]          gyro_gain_reg;
    logic signed [ISS_VAL_W-1:0]   gyro_off_reg [ISS_MAX_AXES];
    logic [ISS_ALPHA_W-1:0]        accel_alpha_reg;
    logic [ISS_ALPHA_W-1:0]        gyro_alpha_reg;

    logic                          do_acc_reg;
    logic                          do_gyr_reg;
    iss_cmd_t                      cmd_in;

    logic signed [ISS_VAL_W-1:0]   acc_scaled [ISS_MAX_AXES];
    logic signed [ISS_VAL_W-1:0]   acc_smooth [ISS_MAX_AXES];
    logic signed [ISS_VAL_W-1:0]   gyr_scaled [ISS_MAX_AXES];
    logic signed [ISS_VAL_W-1:0]   gyr_smooth [ISS_MAX_AXES];

    logic [ISS_OUT_W-1:0]          out_data_reg;
    logic [ISS_OUT_W-1:0]          out_data_next;
    logic                          out_valid_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_gain_reg  <= ISS_ACCEL_GAIN_RST;
            gyro_gain_reg   <= ISS_GYRO_GAIN_RST;
            gyro_off_reg[0] <= ISS_GYRO_OFF_X_RST;
            gyro_off_reg[1] <= ISS_GYRO_OFF_Y_RST;
            gyro_off_reg[2] <= ISS_GYRO_OFF_Z_RST;
            accel_alpha_reg <= ISS_ALPHA_RST;
            gyro_alpha_reg  <= ISS_ALPHA_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACCEL_GAIN:    accel_gain_reg  <= cfg_data;
                REG_GYRO_GAIN:     gyro_gain_reg   <= cfg_data;
                REG_GYRO_OFFSET_X: gyro_off_reg[0] <= cfg_data;
                REG_GYRO_OFFSET_Y: gyro_off_reg[1] <= cfg_data;
                REG_GYRO_OFFSET_Z: gyro_off_reg[2] <= cfg_data;
                REG_ACCEL_ALPHA:   accel_alpha_reg <= cfg_data[ISS_ALPHA_W-1:0];
                REG_GYRO_ALPHA:    gyro_alpha_reg  <= cfg_data[ISS_ALPHA_W-1:0];
                default:           ;
            endcase
        end
    end

    // Decode the group selection on acceptance
    assign cmd_in = iss_cmd_t'(s_tdata[ISS_CMD_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            do_acc_reg <= 1'b0;
            do_gyr_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            do_acc_reg <= (cmd_in == CMD_BOTH) || (cmd_in == CMD_ACCEL);
            do_gyr_reg <= (cmd_in == CMD_BOTH) || (cmd_in == CMD_GYRO);
        end
    end

    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (out_valid_reg),
        .out_ready (m_tready),
        .ctrl      (ctrl)
    );

    // Lanes: one accel and one gyro lane per implemented axis
    for (genvar a = 0; a < ISS_MAX_AXES; a++)
    begin : g_axis
        if (a < Axes)
        begin : g_lane
            iss_lane u_acc (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .active (do_acc_reg),
                .raw    (s_tdata[ISS_CMD_W + a*ISS_RAW_W +: ISS_RAW_W]),
                .gain   (accel_gain_reg),
                .offset ('0),
                .alpha  (accel_alpha_reg),
                .scaled (acc_scaled[a]),
                .smooth (acc_smooth[a])
            );
            iss_lane u_gyr (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .active (do_gyr_reg),
                .raw    (s_tdata[GYRO_BASE + a*ISS_RAW_W +: ISS_RAW_W]),
                .gain   (gyro_gain_reg),
                .offset (gyro_off_reg[a]),
                .alpha  (gyro_alpha_reg),
                .scaled (gyr_scaled[a]),
                .smooth (gyr_smooth[a])
            );
        end
        else
        begin : g_none
            assign acc_scaled[a] = '0;
            assign acc_smooth[a] = '0;
            assign gyr_scaled[a] = '0;
            assign gyr_smooth[a] = '0;
        end
    end

    // Merge the lane stores into one result word
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < ISS_MAX_AXES; i++)
        begin
            out_data_next[i*ISS_VAL_W +: ISS_VAL_W]       = acc_scaled[i];
            out_data_next[(3+i)*ISS_VAL_W +: ISS_VAL_W]   = gyr_scaled[i];
            out_data_next[(6+i)*ISS_VAL_W +: ISS_VAL_W]   = acc_smooth[i];
            out_data_next[(9+i)*ISS_VAL_W +: ISS_VAL_W]   = gyr_smooth[i];
        end
    end

    // Output register: load when free, drop valid when taken
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample accepted while one is in flight");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> m_tvalid)
        else $error("result load did not raise valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##4 (ctrl.out_load || !(!m_tvalid || m_tready)))
        else $error("sample did not reach the output stage on time");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU sample scale and filter block. Samples go in
// over s_axis with random gaps and results are pulled over m_axis with random
// stalls. A local model of the gain, offset and smoothing arithmetic predicts
// every result. The run walks the corner samples first and then random
// samples under several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import iss_pkg::*;

    // Index that decodes to no register
    localparam logic [ISS_IDX_W-1:0] REG_INDEX_UNUSED = 3'd7;
    localparam int CORNER_ROWS    = 12;
    localparam int SAMPLES_PER_SET = 80;
    localparam int REG_SETS        = 6;

    // One corner sample; raw[0] is accel x, raw[5] is gyro z
    typedef struct packed {
        iss_cmd_t                  cmd;
        logic [5:0][ISS_RAW_W-1:0] raw;
        logic                      all_zero;
    } corner_row_t;

    logic                 clk;
    logic                 rst_n;
    logic [ISS_IN_W-1:0]  s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [ISS_OUT_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_we;
    logic [ISS_IDX_W-1:0] cfg_index;
    logic [ISS_CFG_W-1:0] cfg_data;

    // Local copy of the registers
    logic [ISS_CFG_W-1:0]          accel_gain_q;
    logic [ISS_CFG_W-1:0]          gyro_gain_q;
    logic signed [ISS_VAL_W-1:0]   gyro_offset_q [3];
    logic [ISS_ALPHA_W-1:0]        accel_alpha_q;
    logic [ISS_ALPHA_W-1:0]        gyro_alpha_q;

    // Local copy of the filter stores
    logic signed [ISS_VAL_W-1:0]   accel_scaled_q [3];
    logic signed [ISS_VAL_W-1:0]   gyro_scaled_q  [3];
    logic signed [ISS_VAL_W-1:0]   accel_smooth_q [3];
    logic signed [ISS_VAL_W-1:0]   gyro_smooth_q  [3];

    logic [ISS_OUT_W-1:0] filtered_frames_q [$];
    corner_row_t          corner_rows [CORNER_ROWS];

    int  fail_count;
    int  frames_checked;
    int  cmd_seen [4];
    bit  tx_quiet;
    bit  rx_quiet;

    imu_sample_scale_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model arithmetic
    // ------------------------------------------------------------------------

    // Clamp to the signed 32-bit range
    function automatic logic signed [ISS_VAL_W-1:0] clamp_q16(input longint v);
        logic signed [ISS_VAL_W-1:0] r;
        if (v > longint'(ISS_VAL_MAX))
        begin
            r = ISS_VAL_MAX;
        end
        else if (v < longint'(ISS_VAL_MIN))
        begin
            r = ISS_VAL_MIN;
        end
        else
        begin
            r = v[ISS_VAL_W-1:0];
        end
        return r;
    endfunction

    // floor(raw * gain / 2^16), saturated
    function automatic logic signed [ISS_VAL_W-1:0] apply_gain(
        input logic signed [ISS_RAW_W-1:0] raw,
        input logic [ISS_CFG_W-1:0]        gain
    );
        longint g;
        longint p;
        g = 0;
        g[ISS_CFG_W-1:0] = gain;
        p = longint'(raw) * g;
        return clamp_q16(p >>> 16);
    endfunction

    // First-order smoother; alpha above one holds the old value
    function automatic logic signed [ISS_VAL_W-1:0] blend(
        input logic signed [ISS_VAL_W-1:0] y,
        input logic signed [ISS_VAL_W-1:0] x,
        input logic [ISS_ALPHA_W-1:0]      alpha
    );
        longint a;
        longint acc;
        a = (alpha > ISS_ONE_Q16) ? 65536 : longint'(alpha);
        acc = longint'(y) * a + longint'(x) * (65536 - a);
        acc = acc >>> 16;
        return acc[ISS_VAL_W-1:0];
    endfunction

    // Advance the local stores by one sample and return the expected frame
    function automatic logic [ISS_OUT_W-1:0] filter_sample(
        input iss_cmd_t                  cmd,
        input logic [5:0][ISS_RAW_W-1:0] raw
    );
        logic [ISS_OUT_W-1:0]        frame;
        logic signed [ISS_VAL_W-1:0] s;
        bit                          do_accel;
        bit                          do_gyro;
        do_accel = (cmd == CMD_BOTH) || (cmd == CMD_ACCEL);
        do_gyro  = (cmd == CMD_BOTH) || (cmd == CMD_GYRO);
        for (int i = 0; i < 3; i++)
        begin
            if (do_accel)
            begin
                s = apply_gain(raw[i], accel_gain_q);
                accel_scaled_q[i] = s;
                accel_smooth_q[i] = blend(accel_smooth_q[i], s, accel_alpha_q);
            end
            if (do_gyro)
            begin
                s = apply_gain(raw[3 + i], gyro_gain_q);
                s = clamp_q16(longint'(s) - longint'(gyro_offset_q[i]));
                gyro_scaled_q[i] = s;
                gyro_smooth_q[i] = blend(gyro_smooth_q[i], s, gyro_alpha_q);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            frame[ISS_VAL_W * i       +: ISS_VAL_W] = accel_scaled_q[i];
            frame[ISS_VAL_W * (3 + i) +: ISS_VAL_W] = gyro_scaled_q[i];
            frame[ISS_VAL_W * (6 + i) +: ISS_VAL_W] = accel_smooth_q[i];
            frame[ISS_VAL_W * (9 + i) +: ISS_VAL_W] = gyro_smooth_q[i];
        end
        return frame;
    endfunction

    function automatic string field_name(input int k);
        string grp;
        string axis;
        string kind;
        grp  = ((k % 6) < 3) ? "accel" : "gyro";
        kind = (k < 6) ? "scaled" : "smooth";
        unique case (k % 3)
            0:       axis = "x";
            1:       axis = "y";
            default: axis = "z";
        endcase
        return $sformatf("%s_%s_%s", grp, axis, kind);
    endfunction

    // ------------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------------

    // Write one register and mirror it locally; unknown indexes are dropped
    task automatic write_reg(input logic [ISS_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        unique case (idx)
            REG_ACCEL_GAIN:    accel_gain_q     = data;
            REG_GYRO_GAIN:     gyro_gain_q      = data;
            REG_GYRO_OFFSET_X: gyro_offset_q[0] = data;
            REG_GYRO_OFFSET_Y: gyro_offset_q[1] = data;
            REG_GYRO_OFFSET_Z: gyro_offset_q[2] = data;
            REG_ACCEL_ALPHA:   accel_alpha_q    = data[ISS_ALPHA_W-1:0];
            REG_GYRO_ALPHA:    gyro_alpha_q     = data[ISS_ALPHA_W-1:0];
            default:           ;
        endcase
    endtask

    // Present one sample, hold it until the transaction, then queue its frame
    task automatic send_sample(
        input iss_cmd_t                  cmd,
        input logic [5:0][ISS_RAW_W-1:0] raw,
        input bit                        all_zero
    );
        int                   gap;
        logic [ISS_OUT_W-1:0] frame;
        if ($urandom_range(0, 31) == 0)
        begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ISS_IN_W - ISS_IN_BITS){1'b0}}, raw, cmd};
        do
        begin
            @(posedge clk);
        end
        while (!(s_tvalid && s_tready));
        frame = filter_sample(cmd, raw);
        filtered_frames_q.push_back(all_zero ? '0 : frame);
        cmd_seen[cmd]++;
    endtask

    // Random sample; mostly converting commands, raw values lean to extremes
    task automatic send_random_sample();
        iss_cmd_t                  cmd;
        logic [5:0][ISS_RAW_W-1:0] raw;
        if ($urandom_range(0, 11) == 0)
        begin
            cmd = CMD_NONE;
        end
        else
        begin
            cmd = iss_cmd_t'($urandom_range(CMD_BOTH, CMD_ACCEL));
        end
        for (int i = 0; i < 6; i++)
        begin
            case ($urandom_range(0, 15))
                0:       raw[i] = 16'h7FFF;
                1:       raw[i] = 16'h8000;
                2:       raw[i] = 16'h0000;
                3:       raw[i] = 16'hFFFF;
                default: raw[i] = ISS_RAW_W'($urandom);
            endcase
        end
        send_sample(cmd, raw, 1'b0);
    endtask

    // Drop valid and wait until every queued frame has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (filtered_frames_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register settings for each set; the first runs on the reset values
    task automatic load_reg_set(input int set);
        case (set)
            1:
            begin
                write_reg(REG_ACCEL_GAIN, 32'hFFFF_FFFF);
                write_reg(REG_GYRO_GAIN, 32'hFFFF_FFFF);
                write_reg(REG_GYRO_OFFSET_X, 32'h7FFF_FFFF);
                write_reg(REG_GYRO_OFFSET_Y, 32'h8000_0000);
                write_reg(REG_GYRO_OFFSET_Z, 32'h0000_0000);
                write_reg(REG_ACCEL_ALPHA, 32'd0);
                write_reg(REG_GYRO_ALPHA, 32'd65536);
            end
            2:
            begin
                write_reg(REG_ACCEL_GAIN, 32'd0);
                write_reg(REG_GYRO_GAIN, 32'd0);
                write_reg(REG_GYRO_OFFSET_X, 32'h8000_0000);
                write_reg(REG_GYRO_OFFSET_Y, 32'h7FFF_FFFF);
                write_reg(REG_GYRO_OFFSET_Z, 32'hFFFF_FFFF);
                // upper data bits fall away, leaving an alpha above one
                write_reg(REG_ACCEL_ALPHA, 32'hFFFF_FFFF);
                write_reg(REG_GYRO_ALPHA, 32'd65537);
            end
            3:
            begin
                write_reg(REG_INDEX_UNUSED, $urandom);
                write_reg(REG_ACCEL_GAIN, $urandom);
                write_reg(REG_GYRO_GAIN, $urandom);
                write_reg(REG_GYRO_OFFSET_X, $urandom);
                write_reg(REG_GYRO_OFFSET_Y, $urandom);
                write_reg(REG_GYRO_OFFSET_Z, $urandom);
                write_reg(REG_ACCEL_ALPHA, $urandom_range(0, 65536));
                write_reg(REG_GYRO_ALPHA, $urandom_range(0, 65536));
            end
            4:
            begin
                write_reg(REG_ACCEL_GAIN, $urandom_range(0, 32'h00FF_FFFF));
                write_reg(REG_GYRO_GAIN, $urandom_range(0, 32'h00FF_FFFF));
                write_reg(REG_GYRO_OFFSET_X, $urandom_range(0, 4095) - 2048);
                write_reg(REG_GYRO_OFFSET_Y, $urandom_range(0, 4095) - 2048);
                write_reg(REG_GYRO_OFFSET_Z, $urandom_range(0, 4095) - 2048);
                write_reg(REG_ACCEL_ALPHA, $urandom_range(0, 131071));
                write_reg(REG_GYRO_ALPHA, $urandom_range(0, 131071));
                write_reg(REG_INDEX_UNUSED, 32'h0000_0000);
            end
            default:
            begin
                write_reg(REG_ACCEL_GAIN, ISS_ACCEL_GAIN_RST);
                write_reg(REG_GYRO_GAIN, ISS_GYRO_GAIN_RST);
                write_reg(REG_GYRO_OFFSET_X, ISS_GYRO_OFF_X_RST);
                write_reg(REG_GYRO_OFFSET_Y, ISS_GYRO_OFF_Y_RST);
                write_reg(REG_GYRO_OFFSET_Z, ISS_GYRO_OFF_Z_RST);
                write_reg(REG_ACCEL_ALPHA, 32'(ISS_ALPHA_RST));
                write_reg(REG_GYRO_ALPHA, 32'(ISS_ALPHA_RST));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Stall m_tready at random, with quiet stretches
    initial
    begin
        int stall;
        m_tready = 1'b0;
        rx_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                rx_quiet = !rx_quiet;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 6);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(m_tvalid && m_tready));
        end
    end

    // Compare each result transaction against the oldest queued frame
    always @(posedge clk)
    begin
        logic [ISS_OUT_W-1:0]        want;
        logic signed [ISS_VAL_W-1:0] w;
        logic signed [ISS_VAL_W-1:0] g;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (filtered_frames_q.size() == 0)
            begin
                $error("result transaction with no sample pending");
                fail_count++;
            end
            else
            begin
                want = filtered_frames_q.pop_front();
                frames_checked++;
                for (int k = 0; k < 12; k++)
                begin
                    w = want[ISS_VAL_W * k +: ISS_VAL_W];
                    g = m_tdata[ISS_VAL_W * k +: ISS_VAL_W];
                    if (w !== g)
                    begin
                        $error("%s: expected %0d, got %0d", field_name(k), w, g);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        fail_count     = 0;
        frames_checked = 0;
        tx_quiet       = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            cmd_seen[c] = 0;
        end
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Register values and stores after reset
        accel_gain_q  = ISS_ACCEL_GAIN_RST;
        gyro_gain_q   = ISS_GYRO_GAIN_RST;
        gyro_offset_q[0] = ISS_GYRO_OFF_X_RST;
        gyro_offset_q[1] = ISS_GYRO_OFF_Y_RST;
        gyro_offset_q[2] = ISS_GYRO_OFF_Z_RST;
        accel_alpha_q = ISS_ALPHA_RST;
        gyro_alpha_q  = ISS_ALPHA_RST;
        for (int i = 0; i < 3; i++)
        begin
            accel_scaled_q[i] = '0;
            gyro_scaled_q[i]  = '0;
            accel_smooth_q[i] = '0;
            gyro_smooth_q[i]  = '0;
        end

        // Corner samples, gyro z first in each raw list; the first two must
        // leave every store at zero (no conversion, then accel of all zeros)
        corner_rows[0]  = '{CMD_NONE,  {16'h7FFF, 16'h8000, 16'h1234,
                                        16'hFFFF, 16'h7FFF, 16'h8000}, 1'b1};
        corner_rows[1]  = '{CMD_ACCEL, {16'h7FFF, 16'h8000, 16'hFFFF,
                                        16'h0000, 16'h0000, 16'h0000}, 1'b1};
        corner_rows[2]  = '{CMD_GYRO,  {16'h0000, 16'h0000, 16'h0000,
                                        16'h7FFF, 16'h8000, 16'h0001}, 1'b0};
        corner_rows[3]  = '{CMD_BOTH,  {6{16'h7FFF}}, 1'b0};
        corner_rows[4]  = '{CMD_BOTH,  {6{16'h8000}}, 1'b0};
        corner_rows[5]  = '{CMD_BOTH,  {6{16'hFFFF}}, 1'b0};
        corner_rows[6]  = '{CMD_BOTH,  {6{16'h0001}}, 1'b0};
        corner_rows[7]  = '{CMD_ACCEL, {16'h8000, 16'h7FFF, 16'h8000,
                                        16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0};
        corner_rows[8]  = '{CMD_GYRO,  {16'h7FFF, 16'h8000, 16'h7FFF,
                                        16'h8000, 16'h7FFF, 16'h8000}, 1'b0};
        corner_rows[9]  = '{CMD_NONE,  {16'h0F0F, 16'hF0F0, 16'h00FF,
                                        16'hFF00, 16'h3C3C, 16'hC3C3}, 1'b0};
        corner_rows[10] = '{CMD_BOTH,  {3{16'h5555, 16'hAAAA}}, 1'b0};
        corner_rows[11] = '{CMD_BOTH,  {3{16'hAAAA, 16'h5555}}, 1'b0};

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int set = 0; set < REG_SETS; set++)
        begin
            if (set != 0)
            begin
                load_reg_set(set);
            end
            else
            begin
                for (int r = 0; r < CORNER_ROWS; r++)
                begin
                    send_sample(corner_rows[r].cmd, corner_rows[r].raw,
                                corner_rows[r].all_zero);
                end
            end
            repeat (SAMPLES_PER_SET) send_random_sample();
            drain();
        end

        // Let any stray result show up
        repeat (20) @(posedge clk);

        $display("Checked %0d result frames over %0d register settings", frames_checked,
                 REG_SETS);
        $display("Commands sent: both %0d, gyro %0d, accel %0d, none %0d",
                 cmd_seen[CMD_BOTH], cmd_seen[CMD_GYRO], cmd_seen[CMD_ACCEL],
                 cmd_seen[CMD_NONE]);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/iss_pkg.sv
src/iss_lane.sv
src/iss_ctrl.sv
src/imu_sample_scale_filter.sv
verif/tb_top.sv
